// ===== hdl/tfr_pkg.sv =====
package tfr_pkg;

    localparam int SEQ_W  = 63;
    localparam int TIME_W = 63;
    localparam int CFG_W  = 5;
    localparam int DROP_W = 32;

    typedef enum logic [2:0] {
        REQ_PUSH    = 3'd0,
        REQ_FIND    = 3'd1,
        REQ_CLOSEST = 3'd2,
        REQ_LATEST  = 3'd3,
        REQ_OLDEST  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN,
        ST_OUT
    } t_state;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic push;   // shift toward older positions, new entry enters cell 0
        logic rot;    // rotate one place toward cell 0
    } t_cell_ctl;

    // query held for the length of a scan
    typedef struct packed {
        t_req              req;
        logic [SEQ_W-1:0]  key;
        logic [TIME_W-1:0] target;
        logic              past;
    } t_query;

endpackage

// ===== hdl/tfr_cell.sv =====
module tfr_cell
    import tfr_pkg::*;
#(
    parameter int HANDLE_BITS = 32
) (
    input  logic                   i_clk,
    input  t_cell_ctl              i_ctl,
    input  logic [HANDLE_BITS-1:0] i_push_handle,
    input  logic [SEQ_W-1:0]       i_push_seq,
    input  logic [TIME_W-1:0]      i_push_time,
    input  logic [HANDLE_BITS-1:0] i_rot_handle,
    input  logic [SEQ_W-1:0]       i_rot_seq,
    input  logic [TIME_W-1:0]      i_rot_time,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic [SEQ_W-1:0]       o_seq,
    output logic [TIME_W-1:0]      o_time
);

    logic [HANDLE_BITS-1:0] r_handle;
    logic [SEQ_W-1:0]       r_seq;
    logic [TIME_W-1:0]      r_time;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_handle <= i_push_handle;
            r_seq    <= i_push_seq;
            r_time   <= i_push_time;
        end else if (i_ctl.rot) begin
            r_handle <= i_rot_handle;
            r_seq    <= i_rot_seq;
            r_time   <= i_rot_time;
        end
    end

    assign o_handle = r_handle;
    assign o_seq    = r_seq;
    assign o_time   = r_time;

endmodule

// ===== hdl/tfr_scan.sv =====
module tfr_scan
    import tfr_pkg::*;
#(
    parameter int HANDLE_BITS = 32,
    parameter int DEPTH       = 16,
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_step,
    input  logic [IDX_W-1:0]       i_k,
    input  logic [CNT_W-1:0]       i_count,
    input  t_query                 i_query,
    input  logic [HANDLE_BITS-1:0] i_handle,
    input  logic [SEQ_W-1:0]       i_seq,
    input  logic [TIME_W-1:0]      i_time,
    output logic                   o_found,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic [SEQ_W-1:0]       o_seq,
    output logic [TIME_W-1:0]      o_time
);

    // stage 1: distance and match flags of the entry passing cell 0
    logic [TIME_W-1:0]      w_diff;
    logic                   w_le;
    logic                   w_in;
    logic                   w_hit;

    logic                   r_s1_v;
    logic                   r_s1_in;
    logic                   r_s1_hit;
    logic                   r_s1_le;
    logic [TIME_W-1:0]      r_s1_d;
    logic [HANDLE_BITS-1:0] r_s1_handle;
    logic [SEQ_W-1:0]       r_s1_seq;
    logic [TIME_W-1:0]      r_s1_time;

    // stage 2: running best overall and best at or before target
    logic                   r_hb;
    logic                   r_hp;
    logic [TIME_W-1:0]      r_bd;
    logic [TIME_W-1:0]      r_pd;
    logic [HANDLE_BITS-1:0] r_b_handle;
    logic [SEQ_W-1:0]       r_b_seq;
    logic [TIME_W-1:0]      r_b_time;
    logic [HANDLE_BITS-1:0] r_p_handle;
    logic [SEQ_W-1:0]       r_p_seq;
    logic [TIME_W-1:0]      r_p_time;
    logic                   w_take_b;
    logic                   w_take_p;
    logic                   w_closest;

    assign w_closest = (i_query.req == REQ_CLOSEST);

    always_comb begin
        w_le   = (i_time <= i_query.target);
        w_diff = w_le ? (i_query.target - i_time) : (i_time - i_query.target);
        w_in   = (CNT_W'(i_k) < i_count);
        unique case (i_query.req)
            REQ_FIND:   w_hit = (i_seq == i_query.key);
            REQ_LATEST: w_hit = (i_k == '0);
            REQ_OLDEST: w_hit = (CNT_W'(i_k) == (i_count - CNT_W'(1)));
            default:    w_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_s1_in     <= w_in;
            r_s1_hit    <= w_hit;
            r_s1_le     <= w_le;
            r_s1_d      <= w_diff;
            r_s1_handle <= i_handle;
            r_s1_seq    <= i_seq;
            r_s1_time   <= i_time;
        end
    end

    // scan runs newest first; ties keep the larger sequence, which is the newer entry
    always_comb begin
        w_take_b = 1'b0;
        w_take_p = 1'b0;
        if (r_s1_v && r_s1_in) begin
            if (w_closest) begin
                w_take_b = !r_hb || (r_s1_d < r_bd) ||
                           ((r_s1_d == r_bd) && (r_s1_seq >= r_b_seq));
                w_take_p = r_s1_le && (!r_hp || (r_s1_d < r_pd) ||
                           ((r_s1_d == r_pd) && (r_s1_seq >= r_p_seq)));
            end else begin
                w_take_b = r_s1_hit && !r_hb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb <= 1'b0;
            r_hp <= 1'b0;
        end else if (i_start) begin
            r_hb <= 1'b0;
            r_hp <= 1'b0;
        end else begin
            if (w_take_b) begin
                r_hb <= 1'b1;
            end
            if (w_take_p) begin
                r_hp <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_b) begin
            r_bd       <= r_s1_d;
            r_b_handle <= r_s1_handle;
            r_b_seq    <= r_s1_seq;
            r_b_time   <= r_s1_time;
        end
        if (w_take_p) begin
            r_pd       <= r_s1_d;
            r_p_handle <= r_s1_handle;
            r_p_seq    <= r_s1_seq;
            r_p_time   <= r_s1_time;
        end
    end

    always_comb begin
        if (w_closest && i_query.past && r_hp) begin
            o_found  = 1'b1;
            o_handle = r_p_handle;
            o_seq    = r_p_seq;
            o_time   = r_p_time;
        end else if (r_hb) begin
            o_found  = 1'b1;
            o_handle = r_b_handle;
            o_seq    = r_b_seq;
            o_time   = r_b_time;
        end else begin
            o_found  = 1'b0;
            o_handle = '0;
            o_seq    = '0;
            o_time   = '0;
        end
    end

endmodule

// ===== hdl/timestamped_frame_ring_lookup.sv =====
// push and unused request codes: result is loaded into the output register on acceptance
// queries: the chain rotates one cell per cycle past the single compare unit at cell 0
//   for a full turn, then the result drains through two compare stages to the output
// throughput: one word per cycle for pushes while results are taken, none during a query
// synchronous active-low reset clears count, sequence, drop counter, depth (to DEPTH)
//   and handshake state; cell contents are not cleared
module timestamped_frame_ring_lookup
    import tfr_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 32,
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [2:0]             i_req_type,
    input  logic [HANDLE_BITS-1:0] i_frame_handle,
    input  logic [TIME_W-1:0]      i_time_value,
    input  logic [SEQ_W-1:0]       i_seq_key,
    input  logic                   i_prefer_past,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_found,
    output logic [HANDLE_BITS-1:0] o_handle_out,
    output logic [SEQ_W-1:0]       o_seq_out,
    output logic [TIME_W-1:0]      o_time_out,
    output logic                   o_overwrote_oldest,
    output logic [CNT_W-1:0]       o_entry_total,
    output logic [DROP_W-1:0]      o_drop_total
);

    localparam logic [IDX_W-1:0] LAST_K = IDX_W'(DEPTH - 1);

    // control state
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;     // entries held
    logic [CNT_W-1:0]  r_depth;     // ring length in use, 1..DEPTH
    logic [SEQ_W-1:0]  r_last_seq;
    logic [DROP_W-1:0] r_drops;
    logic [IDX_W-1:0]  r_k;         // position now at cell 0 during a scan
    t_query            r_query;

    // output register
    logic                   r_o_valid;
    logic                   r_o_found;
    logic [HANDLE_BITS-1:0] r_o_handle;
    logic [SEQ_W-1:0]       r_o_seq;
    logic [TIME_W-1:0]      r_o_time;
    logic                   r_o_overwrote;
    logic [CNT_W-1:0]       r_o_total;
    logic [DROP_W-1:0]      r_o_drops;

    // handshake and sequencing
    t_req              w_req;
    logic              w_is_query;
    logic              w_is_push;
    logic              w_out_free;
    logic              w_in_ready;
    logic              w_acc;
    logic              w_step;
    logic              w_ld_out;

    // push bookkeeping
    logic              w_full;
    logic [CNT_W-1:0]  n_count;
    logic [DROP_W-1:0] n_drops;
    logic [SEQ_W-1:0]  n_last_seq;
    logic [CNT_W-1:0]  w_cfg_depth;

    // chain wiring, position 0 is the newest entry
    t_cell_ctl              w_ctl;
    logic [HANDLE_BITS-1:0] w_handle [DEPTH];
    logic [SEQ_W-1:0]       w_seq    [DEPTH];
    logic [TIME_W-1:0]      w_time   [DEPTH];

    // scan result
    logic                   w_s_found;
    logic [HANDLE_BITS-1:0] w_s_handle;
    logic [SEQ_W-1:0]       w_s_seq;
    logic [TIME_W-1:0]      w_s_time;

    assign w_req      = t_req'(i_req_type);
    assign w_is_push  = (w_req == REQ_PUSH);
    assign w_is_query = (w_req == REQ_FIND) || (w_req == REQ_CLOSEST) ||
                        (w_req == REQ_LATEST) || (w_req == REQ_OLDEST);
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_acc      = i_in_valid && w_in_ready;

    // full ring: a push drops the oldest entry out of the ring length in use
    assign w_full     = (r_count >= r_depth);
    assign n_count    = w_full ? r_count : r_count + CNT_W'(1);
    assign n_drops    = (w_full && (r_drops != '1)) ? r_drops + DROP_W'(1) : r_drops;
    assign n_last_seq = r_last_seq + SEQ_W'(1);

    // out-of-range depth writes: zero acts as one, above DEPTH acts as DEPTH
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_depth = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > DEPTH) begin
            w_cfg_depth = CNT_W'(DEPTH);
        end else begin
            w_cfg_depth = CNT_W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: a query rotates the chain a full turn, then drains the compare stages
    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_step     = 1'b0;
        w_ld_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready = w_out_free;
                if (i_in_valid && w_out_free && w_is_query) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_step = 1'b1;
                if (r_k == LAST_K) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    w_ld_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = w_in_ready;
    assign w_ctl.push = w_acc && w_is_push;
    assign w_ctl.rot  = w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_depth    <= CNT_W'(DEPTH);
            r_last_seq <= '0;
            r_drops    <= '0;
            r_k        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= w_cfg_depth;
                r_count <= '0;
            end else if (w_ctl.push) begin
                r_count    <= n_count;
                r_last_seq <= n_last_seq;
                r_drops    <= n_drops;
            end
            if (w_acc) begin
                r_k <= '0;
            end else if (w_step) begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_query.req    <= w_req;
            r_query.key    <= i_seq_key;
            r_query.target <= i_time_value;
            r_query.past   <= i_prefer_past;
        end
    end

    // row of cells: push shifts toward older positions, rotate moves toward cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            tfr_cell #(
                .HANDLE_BITS(HANDLE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_push_handle(i_frame_handle),
                .i_push_seq   (n_last_seq),
                .i_push_time  (i_time_value),
                .i_rot_handle (w_handle[(i + 1) % DEPTH]),
                .i_rot_seq    (w_seq[(i + 1) % DEPTH]),
                .i_rot_time   (w_time[(i + 1) % DEPTH]),
                .o_handle     (w_handle[i]),
                .o_seq        (w_seq[i]),
                .o_time       (w_time[i])
            );
        end else begin : g_body
            tfr_cell #(
                .HANDLE_BITS(HANDLE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_push_handle(w_handle[i - 1]),
                .i_push_seq   (w_seq[i - 1]),
                .i_push_time  (w_time[i - 1]),
                .i_rot_handle (w_handle[(i + 1) % DEPTH]),
                .i_rot_seq    (w_seq[(i + 1) % DEPTH]),
                .i_rot_time   (w_time[(i + 1) % DEPTH]),
                .o_handle     (w_handle[i]),
                .o_seq        (w_seq[i]),
                .o_time       (w_time[i])
            );
        end
    end

    // compare unit watching cell 0 while the chain turns
    tfr_scan #(
        .HANDLE_BITS(HANDLE_BITS),
        .DEPTH      (DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_step  (w_step),
        .i_k     (r_k),
        .i_count (r_count),
        .i_query (r_query),
        .i_handle(w_handle[0]),
        .i_seq   (w_seq[0]),
        .i_time  (w_time[0]),
        .o_found (w_s_found),
        .o_handle(w_s_handle),
        .o_seq   (w_s_seq),
        .o_time  (w_s_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((w_acc && !w_is_query) || w_ld_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_is_push) begin
            r_o_found     <= 1'b1;
            r_o_handle    <= i_frame_handle;
            r_o_seq       <= n_last_seq;
            r_o_time      <= i_time_value;
            r_o_overwrote <= w_full;
            r_o_total     <= n_count;
            r_o_drops     <= n_drops;
        end else if (w_acc && !w_is_query) begin
            // unused request code: report state, no entry
            r_o_found     <= 1'b0;
            r_o_handle    <= '0;
            r_o_seq       <= '0;
            r_o_time      <= '0;
            r_o_overwrote <= 1'b0;
            r_o_total     <= r_count;
            r_o_drops     <= r_drops;
        end else if (w_ld_out) begin
            r_o_found     <= w_s_found;
            r_o_handle    <= w_s_handle;
            r_o_seq       <= w_s_seq;
            r_o_time      <= w_s_time;
            r_o_overwrote <= 1'b0;
            r_o_total     <= r_count;
            r_o_drops     <= r_drops;
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_found            = r_o_found;
    assign o_handle_out       = r_o_handle;
    assign o_seq_out          = r_o_seq;
    assign o_time_out         = r_o_time;
    assign o_overwrote_oldest = r_o_overwrote;
    assign o_entry_total      = r_o_total;
    assign o_drop_total       = r_o_drops;

    // push into a ring that is not full grows the count by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.push && !i_cfg_we && !w_full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push into non-full ring did not grow count");

    // held entries never exceed the ring length in use
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= r_depth) && (r_depth != '0))
        else $error("entry count above ring length");

    // drain only follows the last rotation step
    a_full_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> ($past(r_state) == ST_SCAN) && ($past(r_k) == LAST_K))
        else $error("scan ended before a full turn of the chain");

    // an overwrite report always comes with a nonzero drop count
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_overwrote) |-> (r_o_drops != '0))
        else $error("overwrite reported with zero drop count");

endmodule
